/* rtl/core/video_bus_address_decoder_core_assert.svh */
// Assertion helpers for the bus decoder core.
// Both sample on clk and are disabled while rst_n is low.
`ifndef VIDEO_BUS_ADDRESS_DECODER_CORE_ASSERT_SVH
`define VIDEO_BUS_ADDRESS_DECODER_CORE_ASSERT_SVH

// Same-cycle implication.
`define VBAD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vbad same-cycle check failed");

// Next-cycle implication.
`define VBAD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vbad next-cycle check failed");

`endif

/* rtl/core/vbad_pkg.sv */
`timescale 1ns / 1ps

package vbad_pkg;

    localparam int ADDR_W = 16;
    localparam int DATA_W = 8;
    localparam int OFFS_W = 17;

    // access kinds
    localparam logic OPC_READ  = 1'b0;
    localparam logic OPC_WRITE = 1'b1;

    // address map
    localparam logic [ADDR_W-1:0] PF_MASK    = 16'hF800;
    localparam logic [ADDR_W-1:0] PF_BASE    = 16'h0800;
    localparam logic [ADDR_W-1:0] WO_MASK    = 16'hFFF8;
    localparam logic [ADDR_W-1:0] WO_BASE    = 16'h1800;
    localparam logic [ADDR_W-1:0] RB_MASK    = 16'hFFF0;
    localparam logic [ADDR_W-1:0] RB_BASE    = 16'h1810;
    localparam logic [ADDR_W-1:0] P1_ADDR    = 16'h1800;
    localparam logic [ADDR_W-1:0] SOUND_ADDR = 16'h1A00;
    localparam logic [ADDR_W-1:0] P2_ADDR    = 16'h1A00;
    localparam logic [ADDR_W-1:0] BANK_ADDR  = 16'h1C00;
    localparam logic [ADDR_W-1:0] DIP_ADDR   = 16'h1C00;

    localparam logic [DATA_W-1:0] DIP_RESET = 8'hBF;

    // ROM window offsets
    localparam logic [OFFS_W-1:0] LOW_WIN_BANKED  = 17'h04000;
    localparam logic [OFFS_W-1:0] LOW_WIN_DEFAULT = 17'h10000;
    localparam logic [OFFS_W-1:0] HIGH_WIN_BANKED  = 17'h06000;
    localparam logic [OFFS_W-1:0] HIGH_WIN_DEFAULT = 17'h12000;

    localparam int RB_COUNT = 4;

    typedef struct packed {
        logic              opcode;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
        logic [DATA_W-1:0] player_one_port;
        logic [DATA_W-1:0] player_two_port;
    } access_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              sound_nmi;
        logic [DATA_W-1:0] sound_latch;
        logic [OFFS_W-1:0] low_window_offset;
        logic [OFFS_W-1:0] high_window_offset;
    } result_t;

    // handshake between the input stage and the result stage
    typedef struct packed {
        logic advance;
        logic cfg_we;
    } stage_ctl_t;

endpackage

/* rtl/core/vbad_if.sv */
`timescale 1ns / 1ps

interface vbad_access_if
    import vbad_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
    logic [DATA_W-1:0] player_one_port;
    logic [DATA_W-1:0] player_two_port;

    modport source (output valid, opcode, address, write_data, player_one_port,
                    player_two_port, input ready);
    modport sink (input valid, opcode, address, write_data, player_one_port,
                  player_two_port, output ready);
endinterface

interface vbad_result_if
    import vbad_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              sound_nmi;
    logic [DATA_W-1:0] sound_latch;
    logic [OFFS_W-1:0] low_window_offset;
    logic [OFFS_W-1:0] high_window_offset;

    modport source (output valid, read_data, sound_nmi, sound_latch, low_window_offset,
                    high_window_offset, input ready);
    modport sink (input valid, read_data, sound_nmi, sound_latch, low_window_offset,
                  high_window_offset, output ready);
endinterface

interface vbad_cfg_if
    import vbad_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

/* rtl/core/vbad_pf_ram.sv */
`timescale 1ns / 1ps
`include "video_bus_address_decoder_core_assert.svh"

module vbad_pf_ram
    import vbad_pkg::*;
#(
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [DATA_W-1:0]        wdata,
    output logic [DATA_W-1:0]        rdata,
    output logic                     clear_busy
);
    localparam int AW = $clog2(DEPTH);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;
    logic [AW-1:0]     clr_cnt_reg;
    logic [AW-1:0]     clr_cnt_next;
    logic              clr_busy_reg;
    logic              clr_busy_next;

    // zeroing sweep after reset, one entry per cycle
    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == AW'(DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata      = rdata_reg;
    assign clear_busy = clr_busy_reg;

    `VBAD_ASSERT_NOW(a_no_access_in_sweep, clr_busy_reg, !(wr_en || rd_en))
    `VBAD_ASSERT_NEXT(a_sweep_ends, clr_busy_reg && clr_cnt_reg == AW'(DEPTH - 1), !clr_busy_reg)
    `VBAD_ASSERT_NOW(a_single_port_use, wr_en, !rd_en)

endmodule

/* rtl/core/vbad_regs.sv */
`timescale 1ns / 1ps

module vbad_regs
    import vbad_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  stage_ctl_t        ctl,
    input  access_t           item,
    input  logic [DATA_W-1:0] pf_rdata,
    input  logic [DATA_W-1:0] cfg_data,
    output result_t           res
);
    logic [DATA_W-1:0] latch_reg;
    logic [DATA_W-1:0] latch_next;
    logic [DATA_W-1:0] bank_reg;
    logic [DATA_W-1:0] bank_next;
    logic [DATA_W-1:0] dip_reg;
    logic [DATA_W-1:0] rb_reg  [RB_COUNT];
    logic [DATA_W-1:0] rb_next [RB_COUNT];
    result_t           res_reg;
    result_t           res_next;

    logic pf_hit;
    logic rb_hit;
    logic rb_low;
    logic is_write;

    assign is_write = (item.opcode == OPC_WRITE);
    assign pf_hit   = (item.address & PF_MASK) == PF_BASE;
    assign rb_hit   = (item.address & RB_MASK) == RB_BASE;
    assign rb_low   = (item.address[3:2] == 2'b00);

    always_comb
    begin
        latch_next = latch_reg;
        bank_next  = bank_reg;
        for (int i = 0; i < RB_COUNT; i++)
        begin
            rb_next[i] = rb_reg[i];
        end
        res_next = '0;

        if (is_write)
        begin
            // playfield writes land in the RAM at accept; the write-only
            // layer words feed the renderer, which is not part of this core
            if (pf_hit || ((item.address & WO_MASK) == WO_BASE))
            begin
                res_next.sound_nmi = 1'b0;
            end
            else if (rb_hit)
            begin
                if (rb_low)
                begin
                    rb_next[item.address[1:0]] = item.write_data;
                end
            end
            else if (item.address == SOUND_ADDR)
            begin
                latch_next         = item.write_data;
                res_next.sound_nmi = 1'b1;
            end
            else if (item.address == BANK_ADDR)
            begin
                bank_next = item.write_data;
            end
        end
        else
        begin
            if (pf_hit)
            begin
                res_next.read_data = pf_rdata;
            end
            else if (rb_hit)
            begin
                if (rb_low)
                begin
                    res_next.read_data = rb_reg[item.address[1:0]];
                end
            end
            else if (item.address == P1_ADDR)
            begin
                res_next.read_data = item.player_one_port;
            end
            else if (item.address == P2_ADDR)
            begin
                res_next.read_data = item.player_two_port;
            end
            else if (item.address == DIP_ADDR)
            begin
                res_next.read_data = dip_reg;
            end
        end

        res_next.sound_latch        = latch_next;
        res_next.low_window_offset  = bank_next[0] ? LOW_WIN_BANKED : LOW_WIN_DEFAULT;
        res_next.high_window_offset = bank_next[1] ? HIGH_WIN_BANKED : HIGH_WIN_DEFAULT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg <= '0;
            bank_reg  <= '0;
            dip_reg   <= DIP_RESET;
            for (int i = 0; i < RB_COUNT; i++)
            begin
                rb_reg[i] <= '0;
            end
        end
        else
        begin
            if (ctl.cfg_we)
            begin
                dip_reg <= cfg_data;
            end
            if (ctl.advance)
            begin
                latch_reg <= latch_next;
                bank_reg  <= bank_next;
                for (int i = 0; i < RB_COUNT; i++)
                begin
                    rb_reg[i] <= rb_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

/* rtl/core/video_bus_address_decoder_core.sv */
`timescale 1ns / 1ps
// A beat goes through the input register, then the result register, to result.valid.
// One beat per cycle without back-pressure; single PF RAM read port, registered at accept.
// Reset: rst_n is asynchronous; control, latch, bank and DIP registers reset at once.
// After reset all PLAYFIELD_DEPTH playfield RAM entries (2048 by default) are zeroed;
// access.ready stays low for that sweep, cfg writes are taken throughout.
`include "video_bus_address_decoder_core_assert.svh"

module video_bus_address_decoder_core
    import vbad_pkg::*;
#(
    parameter int PLAYFIELD_DEPTH = 2048
) (
    input  logic          clk,
    input  logic          rst_n,
    vbad_access_if.sink   access,
    vbad_result_if.source result,
    vbad_cfg_if.sink      cfg
);
    localparam int PF_AW = $clog2(PLAYFIELD_DEPTH);

    // Input stage: the accepted beat, held until the result stage takes it.
    access_t s1_item_reg;
    logic    s1_valid_reg;
    logic    s1_valid_next;
    // Result stage valid.
    logic    out_valid_reg;
    logic    out_valid_next;

    access_t           in_item;
    logic              accept;
    logic              advance;
    logic              clear_busy;
    logic              pf_hit;
    logic [PF_AW-1:0]  pf_idx;
    logic [DATA_W-1:0] pf_rdata;
    stage_ctl_t        ctl;
    result_t           res;

    assign in_item.opcode          = access.opcode;
    assign in_item.address         = access.address;
    assign in_item.write_data      = access.write_data;
    assign in_item.player_one_port = access.player_one_port;
    assign in_item.player_two_port = access.player_two_port;

    // The result register frees when empty or being taken; the input stage
    // moves forward whenever it holds a beat and the result register frees.
    assign advance      = s1_valid_reg && (!out_valid_reg || result.ready);
    assign access.ready = !clear_busy && (!s1_valid_reg || advance);
    assign accept       = access.valid && access.ready;

    // DIP byte register is always writable.
    assign cfg.ready = 1'b1;

    // Playfield lives at 0x0800-0x0FFF with address bit 0 flipped.
    assign pf_hit = (access.address & PF_MASK) == PF_BASE;
    assign pf_idx = access.address[PF_AW-1:0] ^ PF_AW'(1);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= in_item;
        end
    end

    // RAM is read and written at accept, so its effects follow beat order.
    vbad_pf_ram #(
        .DEPTH (PLAYFIELD_DEPTH)
    ) u_pf_ram (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (accept && pf_hit && (access.opcode == OPC_READ)),
        .wr_en      (accept && pf_hit && (access.opcode == OPC_WRITE)),
        .addr       (pf_idx),
        .wdata      (access.write_data),
        .rdata      (pf_rdata),
        .clear_busy (clear_busy)
    );

    assign ctl.advance = advance;
    assign ctl.cfg_we  = cfg.valid && cfg.ready;

    // Decode, register file updates and the result register.
    vbad_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .item     (s1_item_reg),
        .pf_rdata (pf_rdata),
        .cfg_data (cfg.data),
        .res      (res)
    );

    assign result.valid              = out_valid_reg;
    assign result.read_data          = res.read_data;
    assign result.sound_nmi          = res.sound_nmi;
    assign result.sound_latch        = res.sound_latch;
    assign result.low_window_offset  = res.low_window_offset;
    assign result.high_window_offset = res.high_window_offset;

    `VBAD_ASSERT_NEXT(a_accept_fills_s1, accept, s1_valid_reg)
    `VBAD_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_reg)
    `VBAD_ASSERT_NEXT(a_s1_holds, s1_valid_reg && !advance, s1_valid_reg && $stable(s1_item_reg))
    `VBAD_ASSERT_NOW(a_no_accept_in_sweep, clear_busy, !accept)

endmodule
